// ===== sv/nrt_pkg.sv =====
package nrt_pkg;

    localparam int NONCE_SLOTS = 8;
    localparam int HASH_SLOTS  = 8;
    localparam int HASH_WORDS  = 8;
    localparam int WORD_W      = 64;

    localparam int NS_W  = (NONCE_SLOTS > 1) ? $clog2(NONCE_SLOTS) : 1;
    localparam int HS_W  = (HASH_SLOTS > 1) ? $clog2(HASH_SLOTS) : 1;
    localparam int HW_W  = (HASH_WORDS > 1) ? $clog2(HASH_WORDS) : 1;
    localparam int CNT_W = $clog2(HASH_WORDS + 1);
    localparam int ROW_W = NS_W + HS_W;
    localparam int ADR_W = ROW_W + HW_W;
    localparam int ROWS  = 2 ** ROW_W;
    localparam int DEPTH = 2 ** ADR_W;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_RECORDED = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_SEEN     = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_ADD_SCAN,
        S_VFY_FIND,
        S_VFY_SCAN,
        S_VFY_WRITE,
        S_DONE
    } state_t;

endpackage

// ===== sv/nrt_ram.sv =====
module nrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== sv/nonce_replay_tracker.sv =====
// Nonce replay tracker.
// Input channel s_*: s_tuser is cmd (0 add a nonce, 1 one hash word of a verify),
// s_tdata carries nonce in bits 63:0 and hash_word in bits 127:64, s_tlast marks
// the last hash word of a verify, which triggers the check.
// Output channel m_*: m_tdata bits 2:0 carry status; one item per add and one
// per verify word with s_tlast set.
// An add walks the nonce table one slot a cycle through one equality and one
// zero comparator. A verify word without s_tlast is only buffered while idle.
// A verify searches the nonce table slot by slot; if the nonce is found, it
// streams HASH_SLOTS * HASH_WORDS words out of the hash RAM, one a cycle,
// through one compare stage, then writes HASH_WORDS words if the hash is new and a row is free.
// s_tready is high only while no request is in progress; the hash RAM port
// sets the verify time.
// Reset clears the nonce table, the eviction pointer and the per-row valid
// bits of the hash store at once; no clearing pass is needed.
// A stalled receiver holds the result in the output register; a new request
// may start meanwhile, and its result waits until the register frees.
module nonce_replay_tracker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // nonce, hash_word
    input  logic         s_tuser,   // cmd
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata    // status, zero fill
);
    import nrt_pkg::*;

    state_t state_reg, state_next;

    logic [WORD_W-1:0] tbl_reg [NONCE_SLOTS];
    logic [WORD_W-1:0] tbl_next [NONCE_SLOTS];
    logic [WORD_W-1:0] buf_reg [HASH_WORDS];
    logic [WORD_W-1:0] buf_next [HASH_WORDS];
    logic [ROWS-1:0]   valid_reg, valid_next;
    logic [NS_W-1:0]   evict_reg, evict_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] nonce_reg, nonce_next;
    logic [NS_W-1:0]   idx_reg, idx_next;
    logic [NS_W-1:0]   slot_reg, slot_next;
    logic              found_reg, found_next;
    logic              dup_reg, dup_next;
    logic [HS_W-1:0]   hs_reg, hs_next;
    logic [HW_W-1:0]   w_reg, w_next;
    logic [HS_W-1:0]   d_hs_reg, d_hs_next;
    logic [HW_W-1:0]   d_w_reg, d_w_next;
    logic              pend_reg, pend_next;
    logic              dvalid_reg, dvalid_next;
    logic              issued_reg, issued_next;
    logic              same_reg, same_next;
    logic              zero_reg, zero_next;
    logic              seen_reg, seen_next;
    logic              empty_found_reg, empty_found_next;
    logic [HS_W-1:0]   empty_reg, empty_next;
    logic              vfy_reg, vfy_next;
    logic [2:0]        status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;

    logic              accept;
    logic              tbl_eq, tbl_zero, idx_last;
    logic [HW_W-1:0]   bw_addr;
    logic [WORD_W-1:0] bw;
    logic [WORD_W-1:0] rd_word;
    logic              row_same, row_zero, row_end, scan_end, w_last;
    logic              ram_we;
    logic [ADR_W-1:0]  ram_addr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic              out_free;

    nrt_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_hash_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign accept   = s_tvalid && s_tready;
    assign tbl_eq   = (tbl_reg[idx_reg] == nonce_reg);
    assign tbl_zero = (tbl_reg[idx_reg] == '0);
    assign idx_last = (idx_reg == NS_W'(NONCE_SLOTS - 1));
    assign w_last   = (w_reg == HW_W'(HASH_WORDS - 1));
    assign bw_addr  = (state_reg == S_VFY_WRITE) ? w_reg : d_w_reg;
    assign bw       = (CNT_W'(bw_addr) < cnt_reg) ? buf_reg[bw_addr] : '0;
    assign rd_word  = dvalid_reg ? ram_rdata : '0;
    assign row_same = same_reg && (rd_word == bw);
    assign row_zero = zero_reg && (rd_word == '0);
    assign row_end  = pend_reg && (d_w_reg == HW_W'(HASH_WORDS - 1));
    assign scan_end = row_end && (d_hs_reg == HS_W'(HASH_SLOTS - 1));
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = out_valid_reg;
        m_tdata  = {5'd0, out_status_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!s_tuser)
                    begin
                        state_next = S_ADD_SCAN;
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_VFY_FIND;
                    end
                end
            end
            S_ADD_SCAN:
            begin
                if (idx_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_VFY_FIND:
            begin
                if (idx_last)
                begin
                    state_next = (found_reg || tbl_eq) ? S_VFY_SCAN : S_DONE;
                end
            end
            S_VFY_SCAN:
            begin
                if (scan_end)
                begin
                    if (seen_reg || row_same || !(empty_found_reg || row_zero))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_VFY_WRITE;
                    end
                end
            end
            S_VFY_WRITE:
            begin
                if (w_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tbl_next         = tbl_reg;
        buf_next         = buf_reg;
        valid_next       = valid_reg;
        evict_next       = evict_reg;
        cnt_next         = cnt_reg;
        nonce_next       = nonce_reg;
        idx_next         = idx_reg;
        slot_next        = slot_reg;
        found_next       = found_reg;
        dup_next         = dup_reg;
        hs_next          = hs_reg;
        w_next           = w_reg;
        d_hs_next        = d_hs_reg;
        d_w_next         = d_w_reg;
        pend_next        = 1'b0;
        dvalid_next      = dvalid_reg;
        issued_next      = issued_reg;
        same_next        = same_reg;
        zero_next        = zero_reg;
        seen_next        = seen_reg;
        empty_found_next = empty_found_reg;
        empty_next       = empty_reg;
        vfy_next         = vfy_reg;
        status_next      = status_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_addr         = {slot_reg, hs_reg, w_reg};
        ram_wdata        = bw;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    nonce_next = s_tdata[63:0];
                    idx_next   = '0;
                    found_next = 1'b0;
                    dup_next   = 1'b0;
                    vfy_next   = s_tuser;
                    if (s_tuser)
                    begin
                        if (cnt_reg < CNT_W'(HASH_WORDS))
                        begin
                            buf_next[cnt_reg[HW_W-1:0]] = s_tdata[127:64];
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
            end
            S_ADD_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (nonce_reg != '0 && tbl_eq)
                begin
                    dup_next = 1'b1;
                end
                if (tbl_zero)
                begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                end
                if (idx_last)
                begin
                    if (dup_reg || (nonce_reg != '0 && tbl_eq))
                    begin
                        status_next = ST_DUP;
                    end
                    else
                    begin
                        status_next = ST_ADDED;
                        if (tbl_zero)
                        begin
                            tbl_next[idx_reg] = nonce_reg;
                        end
                        else if (found_reg)
                        begin
                            tbl_next[slot_reg] = nonce_reg;
                        end
                        else
                        begin
                            tbl_next[evict_reg] = nonce_reg;
                            for (int j = 0; j < HASH_SLOTS; j++)
                            begin
                                valid_next[{evict_reg, HS_W'(j)}] = 1'b0;
                            end
                            evict_next = (evict_reg == NS_W'(NONCE_SLOTS - 1)) ?
                                         '0 : evict_reg + 1'b1;
                        end
                    end
                end
            end
            S_VFY_FIND:
            begin
                idx_next = idx_reg + 1'b1;
                if (tbl_eq)
                begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                end
                hs_next          = '0;
                w_next           = '0;
                issued_next      = 1'b0;
                same_next        = 1'b1;
                zero_next        = 1'b1;
                seen_next        = 1'b0;
                empty_found_next = 1'b0;
                status_next      = ST_UNKNOWN;
            end
            S_VFY_SCAN:
            begin
                if (!issued_reg)
                begin
                    ram_addr    = {slot_reg, hs_reg, w_reg};
                    dvalid_next = valid_reg[{slot_reg, hs_reg}];
                    d_hs_next   = hs_reg;
                    d_w_next    = w_reg;
                    pend_next   = 1'b1;
                    if (w_last)
                    begin
                        w_next = '0;
                        if (hs_reg == HS_W'(HASH_SLOTS - 1))
                        begin
                            issued_next = 1'b1;
                        end
                        else
                        begin
                            hs_next = hs_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        w_next = w_reg + 1'b1;
                    end
                end
                if (pend_reg)
                begin
                    if (row_end)
                    begin
                        same_next = 1'b1;
                        zero_next = 1'b1;
                        if (row_same)
                        begin
                            seen_next = 1'b1;
                        end
                        if (row_zero && !empty_found_reg)
                        begin
                            empty_found_next = 1'b1;
                            empty_next       = d_hs_reg;
                        end
                    end
                    else
                    begin
                        same_next = row_same;
                        zero_next = row_zero;
                    end
                end
                if (scan_end)
                begin
                    w_next = '0;
                    if (seen_reg || row_same)
                    begin
                        status_next = ST_SEEN;
                    end
                    else if (!(empty_found_reg || row_zero))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_RECORDED;
                    end
                end
            end
            S_VFY_WRITE:
            begin
                ram_we    = 1'b1;
                ram_addr  = {slot_reg, empty_reg, w_reg};
                ram_wdata = bw;
                w_next    = w_reg + 1'b1;
                if (w_last)
                begin
                    valid_next[{slot_reg, empty_reg}] = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (vfy_reg)
                    begin
                        cnt_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            evict_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            for (int i = 0; i < NONCE_SLOTS; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            evict_reg     <= evict_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            tbl_reg       <= tbl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg         <= buf_next;
        nonce_reg       <= nonce_next;
        idx_reg         <= idx_next;
        slot_reg        <= slot_next;
        found_reg       <= found_next;
        dup_reg         <= dup_next;
        hs_reg          <= hs_next;
        w_reg           <= w_next;
        d_hs_reg        <= d_hs_next;
        d_w_reg         <= d_w_next;
        dvalid_reg      <= dvalid_next;
        issued_reg      <= issued_next;
        same_reg        <= same_next;
        zero_reg        <= zero_next;
        seen_reg        <= seen_next;
        empty_found_reg <= empty_found_next;
        empty_reg       <= empty_next;
        vfy_reg         <= vfy_next;
        status_reg      <= status_next;
        out_status_reg  <= out_status_next;
    end

endmodule
